@@ sv/wsw_pkg.sv @@
// shared types, constants and helpers of the wasm section walker
package wsw_pkg;

	// default header length and longest accepted ULEB128 encoding
	localparam int HEADER_BYTES_DEF  = 8;
	localparam int LEB_MAX_BYTES_DEF = 5;

	// depth of the request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// section ids of interest
	localparam logic [7:0] SEC_CODE    = 8'h0a;
	localparam logic [7:0] SEC_MAX_ID  = 8'h0b;

	// body opcodes
	localparam logic [7:0] OP_END    = 8'h0b;
	localparam logic [7:0] OP_RETURN = 8'h0f;

	// walker phases
	typedef enum logic [3:0] {
		PH_HEADER   = 4'd0,
		PH_SECID    = 4'd1,
		PH_SKIPSIZE = 4'd2,
		PH_SKIP     = 4'd3,
		PH_CODESIZE = 4'd4,
		PH_FCOUNT   = 4'd5,
		PH_FSIZE    = 4'd6,
		PH_LOCALS   = 4'd7,
		PH_BODY     = 4'd8
	} phase_t;

	// result event codes
	typedef enum logic [2:0] {
		EV_CODE     = 3'd0,
		EV_DONE     = 3'd1,
		EV_ABORT    = 3'd2,
		EV_TRUNC    = 3'd3,
		EV_LEBLONG  = 3'd4,
		EV_BADSEC   = 3'd5,
		EV_BADFSIZE = 3'd6,
		EV_END      = 3'd7
	} event_t;

	// results caused by one input byte, in delivery order:
	// four return bytes, one event, truncation, module end
	typedef struct packed {
		logic   ret4;
		logic   ev_v;
		event_t ev;
		logic   trunc;
		logic   mod_end;
	} desc_t;

	// bytes that stand for the end opcode
	function automatic logic [7:0] ret_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'hc0;
			2'd1: b = 8'h03;
			2'd2: b = 8'h5f;
			default: b = 8'hd6;
		endcase
		return b;
	endfunction

endpackage

@@ sv/wsw_front.sv @@
// front part: byte walker that classifies each byte into a result request
module wsw_front import wsw_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int LEB_MAX_BYTES = LEB_MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_module,
	output logic       push,
	output desc_t      push_desc
);

	localparam int CntW = (LEB_MAX_BYTES > 1) ? $clog2(LEB_MAX_BYTES) : 1;
	localparam phase_t PhReset = (HEADER_BYTES > 0) ? PH_HEADER : PH_SECID;

	phase_t          phase_q, phase_d;
	logic [31:0]     leb_q, leb_d;
	logic [CntW-1:0] seen_q, seen_d;
	logic [31:0]     rem_q, rem_d;
	logic            abort_q, abort_d;
	logic            err_q, err_d;

	// state after the byte but before the module end reset
	phase_t          phase_pre;
	logic            err_pre;

	// leb byte merge
	logic [5:0]  shamt;
	logic [63:0] shifted;
	logic [31:0] leb_merged;
	logic        leb_done, leb_long;
	logic        rem_zero, rem_last;
	logic [31:0] rem_dec;
	logic        body_abort;

	assign shamt      = 6'({1'b0, seen_q, 3'b000} - {4'b0000, seen_q});
	assign shifted    = {57'd0, in_byte[6:0]} << shamt;
	assign leb_merged = leb_q | ((shamt < 6'd32) ? shifted[31:0] : 32'd0);
	assign leb_done   = !in_byte[7];
	assign leb_long   = in_byte[7] && ((32'(seen_q) + 32'd1) >= 32'(LEB_MAX_BYTES));
	assign rem_zero   = (rem_q == 32'd0);
	assign rem_last   = (rem_q <= 32'd1);
	assign rem_dec    = rem_zero ? 32'd0 : rem_q - 32'd1;
	// body byte that aborts the function
	assign body_abort = !abort_q && (in_byte != OP_END) && (in_byte != OP_RETURN);

	// next state
	always_comb begin
		phase_d = phase_q;
		leb_d   = leb_q;
		seen_d  = seen_q;
		rem_d   = rem_q;
		abort_d = abort_q;
		err_d   = err_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_HEADER, PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_last) phase_d = PH_SECID;
				end
				PH_SECID: begin
					leb_d  = '0;
					seen_d = '0;
					if (in_byte == SEC_CODE) phase_d = PH_CODESIZE;
					else if (in_byte <= SEC_MAX_ID) phase_d = PH_SKIPSIZE;
					else err_d = 1'b1;
				end
				PH_SKIPSIZE, PH_CODESIZE, PH_FCOUNT, PH_FSIZE: begin
					leb_d = leb_merged;
					if (leb_done) begin
						leb_d  = '0;
						seen_d = '0;
						unique case (phase_q)
							PH_SKIPSIZE: begin
								rem_d   = leb_merged;
								phase_d = (leb_merged == 32'd0) ? PH_SECID : PH_SKIP;
							end
							PH_CODESIZE: phase_d = PH_FCOUNT;
							PH_FCOUNT:   phase_d = PH_FSIZE;
							default: begin
								rem_d   = leb_merged;
								phase_d = PH_LOCALS;
							end
						endcase
					end else if (leb_long) begin
						err_d = 1'b1;
					end else begin
						seen_d = seen_q + CntW'(1);
					end
				end
				PH_LOCALS: begin
					if (rem_zero) begin
						err_d = 1'b1;
					end else begin
						rem_d = rem_dec;
						leb_d = leb_merged;
						if (leb_done) begin
							leb_d   = '0;
							seen_d  = '0;
							abort_d = 1'b0;
							phase_d = rem_last ? PH_SECID : PH_BODY;
						end else if (leb_long) begin
							err_d = 1'b1;
						end else begin
							seen_d = seen_q + CntW'(1);
						end
					end
				end
				PH_BODY: begin
					rem_d = rem_dec;
					if (body_abort) abort_d = 1'b1;
					if (rem_last) begin
						abort_d = 1'b0;
						phase_d = PH_SECID;
					end
				end
				default: phase_d = PH_SECID;
			endcase
		end
		phase_pre = phase_d;
		err_pre   = err_d;
		// module end puts everything back to reset
		if (end_of_module) begin
			phase_d = PhReset;
			leb_d   = '0;
			seen_d  = '0;
			rem_d   = 32'(HEADER_BYTES);
			abort_d = 1'b0;
			err_d   = 1'b0;
		end
	end

	// result request for this byte
	always_comb begin
		push_desc = '{ret4: 1'b0, ev_v: 1'b0, ev: EV_CODE, trunc: 1'b0, mod_end: 1'b0};
		if (!err_q) begin
			unique case (phase_q)
				PH_SECID: begin
					if (in_byte > SEC_MAX_ID) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_BADSEC;
					end
				end
				PH_SKIPSIZE, PH_CODESIZE, PH_FCOUNT, PH_FSIZE: begin
					if (leb_long) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_LEBLONG;
					end
				end
				PH_LOCALS: begin
					if (rem_zero) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_BADFSIZE;
					end else if (leb_done && rem_last) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_DONE;
					end else if (leb_long) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_LEBLONG;
					end
				end
				PH_BODY: begin
					if (!abort_q && in_byte == OP_END) push_desc.ret4 = 1'b1;
					if (body_abort) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_ABORT;
					end else if (rem_last && !abort_q) begin
						push_desc.ev_v = 1'b1;
						push_desc.ev   = EV_DONE;
					end
				end
				default: ;
			endcase
		end
		if (end_of_module) begin
			// truncation: no error after this byte and not waiting for a section id
			push_desc.trunc   = !err_pre && (phase_pre != PH_SECID);
			push_desc.mod_end = 1'b1;
		end
	end

	assign push = accept;

	// walker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhReset;
			leb_q   <= '0;
			seen_q  <= '0;
			rem_q   <= 32'(HEADER_BYTES);
			abort_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			leb_q   <= leb_d;
			seen_q  <= seen_d;
			rem_q   <= rem_d;
			abort_q <= abort_d;
			err_q   <= err_d;
		end
	end

endmodule

@@ sv/wsw_queue.sv @@
// short request queue between the front and the back part
module wsw_queue import wsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output desc_t head_desc,
	output logic  empty,
	output logic  full
);

	desc_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign head_desc = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			if (push && !pop) count_q <= count_q + (QUEUE_PTR_W+1)'(1);
			else if (pop && !push) count_q <= count_q - (QUEUE_PTR_W+1)'(1);
		end
	end

endmodule

@@ sv/wsw_back.sv @@
// back part: expands each request into result items on the output register
module wsw_back import wsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  desc_t       head_desc,
	input  logic        empty,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic [7:0]  m_tuser,
	output logic        m_tlast
);

	desc_t      cur_q, sel, rest;
	logic       cur_valid_q;
	logic [1:0] idx_q, sel_idx, rest_idx;
	logic       sel_v, out_free, fire, rest_any;
	event_t     item_ev;
	logic [7:0] item_byte;

	logic       out_valid_q;
	event_t     out_ev_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// pick the request in work and its next item
	always_comb begin
		sel       = cur_valid_q ? cur_q : head_desc;
		sel_idx   = cur_valid_q ? idx_q : 2'd0;
		sel_v     = cur_valid_q || !empty;
		rest      = sel;
		rest_idx  = sel_idx;
		item_ev   = EV_END;
		item_byte = 8'd0;
		if (sel.ret4) begin
			item_ev   = EV_CODE;
			item_byte = ret_byte(sel_idx);
			rest_idx  = sel_idx + 2'd1;
			if (sel_idx == 2'd3) rest.ret4 = 1'b0;
		end else if (sel.ev_v) begin
			item_ev    = sel.ev;
			rest.ev_v  = 1'b0;
		end else if (sel.trunc) begin
			item_ev    = EV_TRUNC;
			rest.trunc = 1'b0;
		end else begin
			item_ev      = EV_END;
			rest.mod_end = 1'b0;
		end
		rest_any = rest.ret4 || rest.ev_v || rest.trunc || rest.mod_end;
	end

	assign out_free = !out_valid_q || m_tready;
	assign fire     = sel_v && out_free;
	assign pop      = fire && !cur_valid_q;

	// request in work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (fire) begin
			cur_valid_q <= rest_any;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cur_q <= rest;
			idx_q <= rest_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_ev_q   <= item_ev;
			out_byte_q <= item_byte;
			out_last_q <= !rest_any;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {5'd0, out_ev_q};
	assign m_tlast  = out_last_q;

endmodule

@@ sv/wasm_section_walker_translator_core.sv @@
// top level of the wasm section walker and body translator
//
// channel  dir  payload
// s_*      in   tdata: in_byte[7:0]; tlast: end_of_module
// m_*      out  tdata: code_byte[7:0]; tuser: event_res[2:0], zero fill; tlast: last
//
// one input byte is taken per cycle while the request queue has room. each
// byte yields up to six result items, delivered one per cycle from the back
// sequencer unless the output stalls, so four-byte return expansions hold the
// input once the queue fills. reset is asynchronous and clears the walker,
// the queue and the output register; no clearing pass.
module wasm_section_walker_translator_core import wsw_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int LEB_MAX_BYTES = LEB_MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	input  logic       s_tlast,   // end_of_module
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // code_byte[7:0]
	output logic [7:0] m_tuser,   // event_res[2:0], zero fill
	output logic       m_tlast    // last
);

	logic  accept, push, pop, empty, full;
	desc_t push_desc, head_desc;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	wsw_front #(
		.HEADER_BYTES  (HEADER_BYTES),
		.LEB_MAX_BYTES (LEB_MAX_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (s_tdata),
		.end_of_module (s_tlast),
		.push          (push),
		.push_desc     (push_desc)
	);

	wsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push && (push_desc.ret4 || push_desc.ev_v
			|| push_desc.trunc || push_desc.mod_end)),
		.push_desc (push_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.empty     (empty),
		.full      (full)
	);

	wsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_desc (head_desc),
		.empty     (empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
